/* rtl/core/gdfs_pkg.sv */
// Shared types and constants for the grid depth-first search block.
// Used by the channel interfaces and the top level; depends on nothing.
package gdfs_pkg;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned COORD_W  = 5;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned LENGTH_W = 11;
   localparam int unsigned STEP_W   = 10;
   localparam int unsigned CSR_W    = 6;
   localparam int unsigned CSR_IDX_W = 1;

   typedef logic [OP_W-1:0] op_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam op_type OP_SET    = 2'd0;
   localparam op_type OP_SEARCH = 2'd1;
   localparam op_type OP_READ   = 2'd2;

   localparam csr_index_type CSR_ROWS = 1'd0;
   localparam csr_index_type CSR_COLS = 1'd1;

   localparam logic [CSR_W-1:0] CSR_DIM_RESET = 6'd32;

endpackage

/* rtl/core/gdfs_req_if.sv */
// Request channel of the grid search: valid/ready handshake and item fields.
// Depends on gdfs_pkg for the field widths.
interface gdfs_req_if
   import gdfs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   op_type              operation;
   logic [COORD_W-1:0]  row;
   logic [COORD_W-1:0]  col;
   logic                blocked_value;
   logic [COORD_W-1:0]  goal_row;
   logic [COORD_W-1:0]  goal_col;
   logic [INDEX_W-1:0]  trace_index;

   modport source (output valid, operation, row, col, blocked_value, goal_row, goal_col,
                   trace_index, input ready);
   modport sink (input valid, operation, row, col, blocked_value, goal_row, goal_col,
                 trace_index, output ready);
endinterface

/* rtl/core/gdfs_rsp_if.sv */
// Response channel of the grid search: valid/ready handshake and result fields.
// Depends on gdfs_pkg for the field widths.
interface gdfs_rsp_if
   import gdfs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                found;
   logic                overflow;
   logic [LENGTH_W-1:0] trace_length;
   logic [COORD_W-1:0]  cell_row;
   logic [COORD_W-1:0]  cell_col;
   logic [STEP_W-1:0]   cell_step;
   logic                parent_valid;
   logic [COORD_W-1:0]  parent_row;
   logic [COORD_W-1:0]  parent_col;

   modport source (output valid, found, overflow, trace_length, cell_row, cell_col,
                   cell_step, parent_valid, parent_row, parent_col, input ready);
   modport sink (input valid, found, overflow, trace_length, cell_row, cell_col,
                 cell_step, parent_valid, parent_row, parent_col, output ready);
endinterface

/* rtl/core/gdfs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gdfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* rtl/core/grid_depth_first_search.sv */
// Grid depth-first search, top level: control sequencer and its four memories.
// Depends on gdfs_pkg, gdfs_req_if, gdfs_rsp_if and gdfs_ram.
//
// Each request transaction sets one cell's blocked flag, runs a whole search or
// reads one trace entry, and yields exactly one response transaction. One request
// is worked on at a time; the next may be accepted while the previous response
// still waits in the output register. A set, an unknown operation or an
// out-of-range trace read goes straight to the response state; an in-range trace
// read first passes through the trace read, record read and result states. A search
// first sweeps the per-cell memory, one entry per cycle. Each pop then passes
// through the pop, pop-wait and check states, and each newly visited cell tests
// every direction and waits on the registered read of the per-cell memory for
// every in-area neighbor. After reset the block runs a clearing pass over the
// blocked map and the per-cell memory before it accepts a request;
// configuration writes are taken at any time. All memory accesses are strictly
// sequenced, so every write lands before a read of the same entry is issued.
module grid_depth_first_search
   import gdfs_pkg::*;
#(
   parameter int unsigned MAX_ROWS    = 32,
   parameter int unsigned MAX_COLS    = 32,
   parameter int unsigned STACK_DEPTH = 4096
) (
   input  logic          clock,
   input  logic          reset,
   gdfs_req_if.sink      req_if,
   gdfs_rsp_if.source    rsp_if,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);
   localparam int unsigned CELLS  = MAX_ROWS * MAX_COLS;
   localparam int unsigned CELL_W = $clog2(CELLS);
   localparam int unsigned RW     = $clog2(MAX_ROWS);
   localparam int unsigned CW     = $clog2(MAX_COLS);
   localparam int unsigned RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int unsigned CCNT_W = $clog2(MAX_COLS + 1);
   localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int unsigned SA_W   = $clog2(STACK_DEPTH);
   localparam int unsigned TC_W   = $clog2(CELLS + 1);
   localparam int unsigned POS_W  = RW + CW;

   // Per-cell search record, cleared at the start of every search.
   typedef struct packed {
      logic              visited;
      logic              parent_valid;
      logic [RW-1:0]     parent_row;
      logic [CW-1:0]     parent_col;
      logic [STEP_W-1:0] step;
   } cell_rec_type;
   localparam int unsigned REC_W = $bits(cell_rec_type);

   typedef struct packed {
      logic [RW-1:0] row;
      logic [CW-1:0] col;
   } pos_type;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_SEED = 4'd2;
   localparam logic [3:0] S_POP  = 4'd3;
   localparam logic [3:0] S_POPW = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_NB   = 4'd6;
   localparam logic [3:0] S_NBW  = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;
   localparam logic [3:0] S_RDT  = 4'd9;
   localparam logic [3:0] S_RDC  = 4'd10;
   localparam logic [3:0] S_RDO  = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   function automatic logic [CELL_W-1:0] cell_addr(pos_type p);
      cell_addr = CELL_W'(32'(p.row) * MAX_COLS + 32'(p.col));
   endfunction

   // Registers.
   logic [3:0]          state_ff, state_in;
   logic                init_ff, init_in;
   logic [CELL_W-1:0]   sweep_ff, sweep_in;
   logic [CSR_W-1:0]    rows_ff, rows_in, cols_ff, cols_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [TC_W-1:0]     tc_ff, tc_in;
   logic                found_ff, found_in, ovf_ff, ovf_in;
   logic [COORD_W-1:0]  srow_ff, srow_in, scol_ff, scol_in;
   logic [COORD_W-1:0]  grow_ff, grow_in, gcol_ff, gcol_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   pos_type             cur_ff, cur_in, nb_ff, nb_in;
   logic [STEP_W-1:0]   cstep_ff, cstep_in;
   logic [1:0]          dir_ff, dir_in;
   logic [COORD_W-1:0]  res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic [STEP_W-1:0]   res_step_ff, res_step_in;
   logic                res_pv_ff, res_pv_in;
   logic [COORD_W-1:0]  res_prow_ff, res_prow_in, res_pcol_ff, res_pcol_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in, rsp_ovf_ff, rsp_ovf_in;
   logic [LENGTH_W-1:0] rsp_len_ff, rsp_len_in;
   logic [COORD_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [STEP_W-1:0]   rsp_step_ff, rsp_step_in;
   logic                rsp_pv_ff, rsp_pv_in;
   logic [COORD_W-1:0]  rsp_prow_ff, rsp_prow_in, rsp_pcol_ff, rsp_pcol_in;

   // Memory ports.
   logic                blk_we, blk_wdata, blk_rdata;
   logic [CELL_W-1:0]   blk_waddr, blk_raddr;
   logic                rec_we;
   logic [CELL_W-1:0]   rec_waddr, rec_raddr;
   cell_rec_type        rec_wdata, rec_rdata;
   logic                stk_we;
   logic [SA_W-1:0]     stk_waddr, stk_raddr;
   pos_type             stk_wdata, stk_rdata;
   logic                trc_we;
   logic [CELL_W-1:0]   trc_waddr, trc_raddr;
   pos_type             trc_wdata, trc_rdata;

   // Active area, with zero acting as one and oversize values clamped.
   logic [RCNT_W-1:0]   rows_eff;
   logic [CCNT_W-1:0]   cols_eff;
   logic                accept, rsp_free, nb_ok, goal_hit;
   pos_type             nb_pos;

   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = RCNT_W'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(32'(rows_ff));
      end
      if (cols_ff == '0) begin
         cols_eff = CCNT_W'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CCNT_W'(MAX_COLS);
      end else begin
         cols_eff = CCNT_W'(32'(cols_ff));
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // The goal only counts when it lies inside the active area.
   assign goal_hit = (32'(grow_ff) < 32'(rows_eff)) && (32'(gcol_ff) < 32'(cols_eff)) &&
                     (32'(cur_ff.row) == 32'(grow_ff)) && (32'(cur_ff.col) == 32'(gcol_ff));

   // Neighbor of the current cell in the direction under test.
   always_comb begin
      nb_pos = cur_ff;
      nb_ok  = 1'b0;
      unique case (dir_ff)
         DIR_NORTH: begin
            nb_ok      = (cur_ff.row != '0);
            nb_pos.row = cur_ff.row - RW'(1);
         end
         DIR_SOUTH: begin
            nb_ok      = (32'(cur_ff.row) + 32'd1 < 32'(rows_eff));
            nb_pos.row = cur_ff.row + RW'(1);
         end
         DIR_EAST: begin
            nb_ok      = (32'(cur_ff.col) + 32'd1 < 32'(cols_eff));
            nb_pos.col = cur_ff.col + CW'(1);
         end
         DIR_WEST: begin
            nb_ok      = (cur_ff.col != '0);
            nb_pos.col = cur_ff.col - CW'(1);
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      init_in    = init_ff;
      sweep_in   = sweep_ff;
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      sp_in      = sp_ff;
      tc_in      = tc_ff;
      found_in   = found_ff;
      ovf_in     = ovf_ff;
      srow_in    = srow_ff;
      scol_in    = scol_ff;
      grow_in    = grow_ff;
      gcol_in    = gcol_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      nb_in      = nb_ff;
      cstep_in   = cstep_ff;
      dir_in     = dir_ff;
      res_row_in = res_row_ff;
      res_col_in = res_col_ff;
      res_step_in = res_step_ff;
      res_pv_in  = res_pv_ff;
      res_prow_in = res_prow_ff;
      res_pcol_in = res_pcol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_prow_in  = rsp_prow_ff;
      rsp_pcol_in  = rsp_pcol_ff;

      blk_we    = 1'b0;
      blk_waddr = sweep_ff;
      blk_wdata = 1'b0;
      blk_raddr = cell_addr(nb_pos);
      rec_we    = 1'b0;
      rec_waddr = sweep_ff;
      rec_wdata = '0;
      rec_raddr = cell_addr(nb_pos);
      stk_we    = 1'b0;
      stk_waddr = SA_W'(sp_ff);
      stk_wdata = nb_ff;
      stk_raddr = SA_W'(sp_ff - SP_W'(1));
      trc_we    = 1'b0;
      trc_waddr = CELL_W'(tc_ff);
      trc_wdata = cur_ff;
      trc_raddr = CELL_W'(32'(idx_ff));

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               srow_in     = req_if.row;
               scol_in     = req_if.col;
               grow_in     = req_if.goal_row;
               gcol_in     = req_if.goal_col;
               idx_in      = req_if.trace_index;
               res_row_in  = '0;
               res_col_in  = '0;
               res_step_in = '0;
               res_pv_in   = 1'b0;
               res_prow_in = '0;
               res_pcol_in = '0;
               state_in    = S_DONE;
               if (req_if.operation == OP_SET) begin
                  blk_we    = (32'(req_if.row) < MAX_ROWS) && (32'(req_if.col) < MAX_COLS);
                  blk_waddr = CELL_W'(32'(req_if.row) * MAX_COLS + 32'(req_if.col));
                  blk_wdata = req_if.blocked_value;
               end else if (req_if.operation == OP_SEARCH) begin
                  sp_in    = '0;
                  tc_in    = '0;
                  found_in = 1'b0;
                  ovf_in   = 1'b0;
                  sweep_in = '0;
                  state_in = S_CLR;
               end else if (req_if.operation == OP_READ) begin
                  if (32'(req_if.trace_index) < 32'(tc_ff)) begin
                     state_in = S_RDT;
                  end
               end
            end
         end
         S_CLR: begin
            // The blocked map is only swept by the pass after reset.
            blk_we   = init_ff;
            rec_we   = 1'b1;
            sweep_in = sweep_ff + CELL_W'(1);
            if (32'(sweep_ff) == CELLS - 1) begin
               sweep_in = '0;
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_SEED;
            end
         end
         S_SEED: begin
            if ((32'(srow_ff) < 32'(rows_eff)) && (32'(scol_ff) < 32'(cols_eff))) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata.row = RW'(32'(srow_ff));
               stk_wdata.col = CW'(32'(scol_ff));
               sp_in     = SP_W'(1);
               state_in  = S_POP;
            end else begin
               state_in  = S_DONE;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               state_in = S_FIN;
            end else begin
               sp_in    = sp_ff - SP_W'(1);
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            cur_in    = stk_rdata;
            rec_raddr = cell_addr(stk_rdata);
            state_in  = S_CHK;
         end
         S_CHK: begin
            if (rec_rdata.visited) begin
               state_in = S_POP;
            end else begin
               rec_we            = 1'b1;
               rec_waddr         = cell_addr(cur_ff);
               rec_wdata         = rec_rdata;
               rec_wdata.visited = 1'b1;
               trc_we            = 1'b1;
               tc_in             = tc_ff + TC_W'(1);
               cstep_in          = rec_rdata.step;
               dir_in            = DIR_NORTH;
               if (goal_hit) begin
                  found_in = 1'b1;
                  state_in = S_FIN;
               end else begin
                  state_in = S_NB;
               end
            end
         end
         S_NB: begin
            if (nb_ok) begin
               nb_in    = nb_pos;
               state_in = S_NBW;
            end else if (dir_ff == DIR_WEST) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NBW: begin
            state_in = (dir_ff == DIR_WEST) ? S_POP : S_NB;
            dir_in   = dir_ff + 2'd1;
            if (!rec_rdata.visited && !blk_rdata) begin
               rec_we                 = 1'b1;
               rec_waddr              = cell_addr(nb_ff);
               rec_wdata.visited      = 1'b0;
               rec_wdata.parent_valid = 1'b1;
               rec_wdata.parent_row   = cur_ff.row;
               rec_wdata.parent_col   = cur_ff.col;
               rec_wdata.step         = cstep_ff + STEP_W'(1);
               if (32'(sp_ff) == STACK_DEPTH) begin
                  ovf_in   = 1'b1;
                  state_in = S_FIN;
               end else begin
                  stk_we = 1'b1;
                  sp_in  = sp_ff + SP_W'(1);
               end
            end
         end
         S_FIN: begin
            if (!found_ff) begin
               tc_in = '0;
            end
            state_in = S_DONE;
         end
         S_RDT: begin
            state_in = S_RDC;
         end
         S_RDC: begin
            rec_raddr  = cell_addr(trc_rdata);
            res_row_in = COORD_W'(32'(trc_rdata.row));
            res_col_in = COORD_W'(32'(trc_rdata.col));
            state_in   = S_RDO;
         end
         S_RDO: begin
            res_step_in = rec_rdata.step;
            res_pv_in   = rec_rdata.parent_valid;
            res_prow_in = rec_rdata.parent_valid ? COORD_W'(32'(rec_rdata.parent_row)) : '0;
            res_pcol_in = rec_rdata.parent_valid ? COORD_W'(32'(rec_rdata.parent_col)) : '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_len_in   = LENGTH_W'(32'(tc_ff));
               rsp_row_in   = res_row_ff;
               rsp_col_in   = res_col_ff;
               rsp_step_in  = res_step_ff;
               rsp_pv_in    = res_pv_ff;
               rsp_prow_in  = res_prow_ff;
               rsp_pcol_in  = res_pcol_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         init_ff      <= 1'b1;
         sweep_ff     <= '0;
         rows_ff      <= CSR_DIM_RESET;
         cols_ff      <= CSR_DIM_RESET;
         sp_ff        <= '0;
         tc_ff        <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         dir_ff       <= DIR_NORTH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         sweep_ff     <= sweep_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         sp_ff        <= sp_in;
         tc_ff        <= tc_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      srow_ff     <= srow_in;
      scol_ff     <= scol_in;
      grow_ff     <= grow_in;
      gcol_ff     <= gcol_in;
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      nb_ff       <= nb_in;
      cstep_ff    <= cstep_in;
      res_row_ff  <= res_row_in;
      res_col_ff  <= res_col_in;
      res_step_ff <= res_step_in;
      res_pv_ff   <= res_pv_in;
      res_prow_ff <= res_prow_in;
      res_pcol_ff <= res_pcol_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_step_ff <= rsp_step_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_prow_ff <= rsp_prow_in;
      rsp_pcol_ff <= rsp_pcol_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.overflow     = rsp_ovf_ff;
   assign rsp_if.trace_length = rsp_len_ff;
   assign rsp_if.cell_row     = rsp_row_ff;
   assign rsp_if.cell_col     = rsp_col_ff;
   assign rsp_if.cell_step    = rsp_step_ff;
   assign rsp_if.parent_valid = rsp_pv_ff;
   assign rsp_if.parent_row   = rsp_prow_ff;
   assign rsp_if.parent_col   = rsp_pcol_ff;

   gdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blocked (
      .clock(clock), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
      .raddr(blk_raddr), .rdata(blk_rdata)
   );

   gdfs_ram #(.WIDTH(REC_W), .DEPTH(CELLS)) u_record (
      .clock(clock), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
      .raddr(rec_raddr), .rdata(rec_rdata)
   );

   gdfs_ram #(.WIDTH(POS_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   gdfs_ram #(.WIDTH(POS_W), .DEPTH(CELLS)) u_trace (
      .clock(clock), .we(trc_we), .waddr(trc_waddr), .wdata(trc_wdata),
      .raddr(trc_raddr), .rdata(trc_rdata)
   );

   // The stack pointer never passes the stack's depth.
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= STACK_DEPTH)
      else $error("stack pointer beyond stack depth");

   // A search never ends both found and overflowed.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      !(found_ff && ovf_ff))
      else $error("found and overflow both set");

   // Once a search is wrapped up, an unsuccessful one leaves an empty trace.
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> (found_ff || tc_ff == '0))
      else $error("trace length nonzero after unsuccessful search");

   // The trace never holds more entries than there are cells.
   a_tc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(tc_ff) <= CELLS)
      else $error("trace count beyond cell count");

endmodule
